@@ rtl/ple_pkg.sv @@
// Package with shared constants, operation codes and status codes of the list engine.
`default_nettype none

package ple_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_REMOVE   = 2'd1,
        MODE_RETRIEVE = 2'd2,
        MODE_UNUSED   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_UNDER = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    // Shift command broadcast to every cell of the row.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/ple_ifs.sv @@
// Request and response channel interfaces of the list engine.
`default_nettype none

interface ple_req_if #(
    parameter int CAPACITY   = ple_pkg::CAPACITY,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH
);
    localparam int PW = $clog2(CAPACITY + 1);

    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic [PW-1:0]         position;
    logic [DATA_WIDTH-1:0] value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface ple_rsp_if #(
    parameter int CAPACITY   = ple_pkg::CAPACITY,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH
);
    localparam int PW = $clog2(CAPACITY + 1);

    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [DATA_WIDTH-1:0] entry_value;
    logic [PW-1:0]         length;

    modport source (output valid, output status, output entry_value, output length,
                    input ready);
    modport sink   (input valid, input status, input entry_value, input length,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/ple_cell.sv @@
// One storage cell of the list row: holds one entry and shifts with its neighbors.
`default_nettype none

module ple_cell #(
    parameter int INDEX      = 0,
    parameter int PW         = 7,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH
) (
    input  wire                   i_clk,
    input  wire ple_pkg::t_cell_ctl i_ctl,
    input  wire [PW-1:0]          i_pos,
    input  wire [DATA_WIDTH-1:0]  i_ins_value,
    input  wire [DATA_WIDTH-1:0]  i_below,
    input  wire [DATA_WIDTH-1:0]  i_above,
    output logic [DATA_WIDTH-1:0] o_value,
    output logic [DATA_WIDTH-1:0] o_read
);
    import ple_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(INDEX);

    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] n_value;
    logic                  w_at;
    logic                  w_past;

    assign w_at   = (i_pos == MY_IDX);
    assign w_past = (MY_IDX > i_pos);

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (w_past) begin
                n_value = i_below;
            end else if (w_at) begin
                n_value = i_ins_value;
            end
        end else if (i_ctl.rem) begin
            if (w_past || w_at) begin
                n_value = i_above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    // Only the addressed cell drives the shared read bus.
    assign o_read  = w_at ? r_value : '0;

endmodule

`default_nettype wire

@@ rtl/positional_list_engine_top.sv @@
// Top level of the positional list engine: a shifting row of entry cells.
//
//  channel | dir | payload                          | handshake
//  i_req   | in  | mode, position, value            | valid/ready
//  o_rsp   | out | status, entry_value, length      | valid/ready
//
// Every request is checked against the entry count, the row of cells shifts at the
// clock edge that accepts it, and the response is registered at that same edge.
// A new request is taken in every cycle in which the response register is empty or
// being drained, so the rate is one request per cycle while o_rsp.ready stays high.
// Reset clears the entry count and the response valid; entry cells are not cleared.
// A stalled response holds its payload and holds off further requests.
`default_nettype none

module positional_list_engine_top #(
    parameter int CAPACITY   = ple_pkg::CAPACITY,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ple_req_if.sink    i_req,
    ple_rsp_if.source  o_rsp
);
    import ple_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] FULL = PW'(CAPACITY);

    logic [PW-1:0]         r_count;
    logic [PW-1:0]         n_count;
    logic                  r_out_valid;
    t_status               r_status;
    logic [DATA_WIDTH-1:0] r_entry_value;
    logic [PW-1:0]         r_length;

    logic                  w_accept;
    t_status               w_status;
    logic [DATA_WIDTH-1:0] w_read;
    t_cell_ctl             w_ctl;
    logic                  w_take_read;

    logic [DATA_WIDTH-1:0] w_vals [CAPACITY];
    logic [DATA_WIDTH-1:0] w_rds  [CAPACITY];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        w_status    = ST_OK;
        w_ctl       = '0;
        w_take_read = 1'b0;
        n_count     = r_count;
        case (t_mode'(i_req.mode))
            MODE_INSERT: begin
                if (r_count == FULL) begin
                    w_status = ST_OVER;
                end else if (i_req.position > r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.ins = w_accept;
                    n_count   = r_count + PW'(1);
                end
            end
            MODE_REMOVE: begin
                if (r_count == '0) begin
                    w_status = ST_UNDER;
                end else if (i_req.position >= r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.rem   = w_accept;
                    w_take_read = 1'b1;
                    n_count     = r_count - PW'(1);
                end
            end
            MODE_RETRIEVE: begin
                if (i_req.position >= r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_take_read = 1'b1;
                end
            end
            default: begin
                w_status = ST_RANGE;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_below;
            logic [DATA_WIDTH-1:0] w_above;
            if (g == 0) begin : g_first
                assign w_below = w_vals[g];
            end else begin : g_mid_lo
                assign w_below = w_vals[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_above = w_vals[g];
            end else begin : g_mid_hi
                assign w_above = w_vals[g+1];
            end
            ple_cell #(
                .INDEX      (g),
                .PW         (PW),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_pos       (i_req.position),
                .i_ins_value (i_req.value),
                .i_below     (w_below),
                .i_above     (w_above),
                .o_value     (w_vals[g]),
                .o_read      (w_rds[g])
            );
        end
    endgenerate

    always_comb begin
        w_read = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_read = w_read | w_rds[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= w_status;
            r_entry_value <= w_take_read ? w_read : '0;
            r_length      <= n_count;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_value = r_entry_value;
    assign o_rsp.length      = r_length;

endmodule

`default_nettype wire

@@ rtl/ple_checker.sv @@
// Port-level checker for the list engine, bound to the top level.
`default_nettype none

module ple_checker #(
    parameter int CAPACITY   = ple_pkg::CAPACITY,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH,
    parameter int PW         = $clog2(CAPACITY + 1)
) (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_req_valid,
    input wire                  i_req_ready,
    input wire                  i_rsp_valid,
    input wire                  i_rsp_ready,
    input wire [1:0]            i_rsp_status,
    input wire [DATA_WIDTH-1:0] i_rsp_entry_value,
    input wire [PW-1:0]         i_rsp_length
);
    import ple_pkg::*;

    // Reset empties the response register.
    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // Every accepted request produces a response in the next cycle.
    a_req_rsp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> i_rsp_valid)
        else $error("accepted request without response");

    a_over_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_OVER |-> i_rsp_length == PW'(CAPACITY))
        else $error("overflow reported while list not full");

    a_fail_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_entry_value == '0)
        else $error("failed request returned a nonzero value");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_entry_value)
            && $stable(i_rsp_length))
        else $error("stalled response changed");

endmodule

bind positional_list_engine_top ple_checker #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
) u_ple_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_entry_value (o_rsp.entry_value),
    .i_rsp_length      (o_rsp.length)
);

`default_nettype wire
